FILE: rtl/core/pwf_pkg.sv
// Constants and slot codes for the page-write framer.
// No dependencies; imported by page_write_framer_top.
`timescale 1ns / 1ps

package pwf_pkg;

  // Field widths
  localparam int unsigned OfsW  = 16;
  localparam int unsigned LenW  = 9;
  localparam int unsigned ByteW = 8;
  localparam int unsigned SumW  = 16;

  // Frame constants
  localparam logic [ByteW-1:0] CMD_WRITE      = 8'hC3;
  localparam logic [SumW-1:0]  SUM_INIT       = 16'hFFFF;
  localparam logic [OfsW-1:0]  OFS_LOW        = 16'h1800;
  localparam logic [OfsW-1:0]  OFS_HIGH       = 16'hF200;
  localparam logic [LenW-1:0]  FORCED_LEN     = 9'h0D5;
  localparam logic [LenW-1:0]  MAX_PAGE_BYTES = 9'd256;
  localparam logic [OfsW-1:0]  LEN_OVERHEAD   = 16'd11;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_PAGE_OFFSET = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PAGE_BYTES  = 2'd1;

  // Output slot codes: position of a byte within the results of one item
  typedef logic [3:0] slot_t;
  localparam slot_t SLOT_LEN_LO  = 4'd0;
  localparam slot_t SLOT_LEN_HI  = 4'd1;
  localparam slot_t SLOT_CMD     = 4'd2;
  localparam slot_t SLOT_OFS_LO  = 4'd3;
  localparam slot_t SLOT_OFS_HI  = 4'd4;
  localparam slot_t SLOT_ZERO_A  = 4'd5;
  localparam slot_t SLOT_ZERO_B  = 4'd6;
  localparam slot_t SLOT_USED_LO = 4'd7;
  localparam slot_t SLOT_USED_HI = 4'd8;
  localparam slot_t SLOT_DATA    = 4'd9;
  localparam slot_t SLOT_SUM_LO  = 4'd10;
  localparam slot_t SLOT_SUM_HI  = 4'd11;
  localparam slot_t SLOT_REJECT  = 4'd12;

endpackage

FILE: rtl/core/page_write_framer_top.sv
// Page-write framer: wraps page data bytes into header, data and checksum, or rejects.
// Depends on pwf_pkg for constants and slot codes.
`timescale 1ns / 1ps

// Path: the results of an accepted item (first header byte, data byte or reject
// marker) pass from the plan register to the output register.
// Throughput: one data byte per cycle while the output is not stalled; the first
// byte of a page holds the input while the header drains and the last byte while
// the checksum drains, through the single output register, one byte per cycle.
// Reset: synchronous; clears page position, checksum, pending bytes and
// returns page_offset to 0x1800 and page_bytes to 256.
module page_write_framer_top
  import pwf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [OfsW-1:0]    cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   data_byte,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ByteW-1:0]   frame_byte,
  output logic               frame_end,
  output logic               rejected
);

  // Configuration registers
  logic [OfsW-1:0] page_offset;
  logic [LenW-1:0] page_bytes;

  // Page state
  logic [LenW-1:0] byte_index;
  logic [SumW-1:0] running_sum;

  // Plan register: the pending results of the item in hand
  logic            plan_valid;
  slot_t           plan_slot;
  slot_t           plan_last;
  logic [OfsW-1:0] plan_total;
  logic [OfsW-1:0] plan_offset;
  logic [LenW-1:0] plan_used;
  logic [ByteW-1:0] plan_data;
  logic [SumW-1:0] plan_sum;

  // Accept-time decode
  logic            in_fire;
  logic [LenW-1:0] n_len;
  logic            wrap_in;
  logic [LenW-1:0] idx;
  logic [SumW-1:0] sum_start;
  logic            reject;
  logic [LenW-1:0] used;
  logic            first;
  logic            emit_data;
  logic            last_byte;
  logic [OfsW-1:0] total;
  logic [SumW-1:0] hdr_sum;
  logic [SumW-1:0] sum_hdr;
  logic [SumW-1:0] sum_after;
  logic [LenW-1:0] idx_inc;
  logic            has_result;
  slot_t           start_slot;
  slot_t           end_slot;

  // Emission
  logic            load;
  logic [ByteW-1:0] slot_byte;

  // Clamp page length and find where this item sits in the page
  always_comb begin
    if (page_bytes == '0) begin
      n_len = LenW'(1);
    end else if (page_bytes > MAX_PAGE_BYTES) begin
      n_len = MAX_PAGE_BYTES;
    end else begin
      n_len = page_bytes;
    end
    wrap_in   = (byte_index >= n_len);
    idx       = wrap_in ? '0 : byte_index;
    sum_start = wrap_in ? SUM_INIT : running_sum;
    reject    = (page_offset < OFS_LOW) || (page_offset > OFS_HIGH);
    used      = (page_offset == OFS_HIGH && n_len >= FORCED_LEN) ? FORCED_LEN : n_len;
    first     = (idx == '0);
    emit_data = !reject && (idx < used);
    idx_inc   = idx + LenW'(1);
    last_byte = emit_data && (idx_inc == used);
    total     = {{(OfsW-LenW){1'b0}}, used} + LEN_OVERHEAD;
  end

  // Sum of all header bytes and the checksum after this item
  always_comb begin
    hdr_sum = {8'h00, total[7:0]} + {8'h00, total[15:8]} + {8'h00, CMD_WRITE}
            + {8'h00, page_offset[7:0]} + {8'h00, page_offset[15:8]}
            + {8'h00, used[7:0]} + {15'h0000, used[8]};
    sum_hdr   = (!reject && first) ? (SUM_INIT - hdr_sum) : sum_start;
    sum_after = emit_data ? (sum_hdr - {8'h00, data_byte}) : sum_hdr;
  end

  // Plan the slots this item produces
  always_comb begin
    has_result = reject ? first : emit_data;
    if (reject) begin
      start_slot = SLOT_REJECT;
      end_slot   = SLOT_REJECT;
    end else begin
      start_slot = first ? SLOT_LEN_LO : SLOT_DATA;
      end_slot   = last_byte ? SLOT_SUM_HI : SLOT_DATA;
    end
  end

  // Select the byte of the current slot
  always_comb begin
    unique case (plan_slot)
      SLOT_LEN_LO:  slot_byte = plan_total[7:0];
      SLOT_LEN_HI:  slot_byte = plan_total[15:8];
      SLOT_CMD:     slot_byte = CMD_WRITE;
      SLOT_OFS_LO:  slot_byte = plan_offset[7:0];
      SLOT_OFS_HI:  slot_byte = plan_offset[15:8];
      SLOT_USED_LO: slot_byte = plan_used[7:0];
      SLOT_USED_HI: slot_byte = {7'b0000000, plan_used[8]};
      SLOT_DATA:    slot_byte = plan_data;
      SLOT_SUM_LO:  slot_byte = plan_sum[7:0];
      SLOT_SUM_HI:  slot_byte = plan_sum[15:8];
      default:      slot_byte = '0;
    endcase
  end

  assign load     = plan_valid && (!out_valid || out_ready);
  assign in_ready = !plan_valid || (load && (plan_slot == plan_last));
  assign in_fire  = in_valid && in_ready;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      page_offset <= OFS_LOW;
      page_bytes  <= MAX_PAGE_BYTES;
    end else if (cfg_we) begin
      if (cfg_index == REG_PAGE_OFFSET) begin
        page_offset <= cfg_data;
      end else if (cfg_index == REG_PAGE_BYTES) begin
        page_bytes <= cfg_data[LenW-1:0];
      end
    end
  end

  // Advance page position and checksum on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_sum <= SUM_INIT;
    end else if (in_fire) begin
      if (idx_inc >= n_len) begin
        byte_index  <= '0;
        running_sum <= SUM_INIT;
      end else begin
        byte_index  <= idx_inc;
        running_sum <= sum_after;
      end
    end
  end

  // Plan control: load a new item or step through its slots
  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
      plan_slot  <= SLOT_DATA;
      plan_last  <= SLOT_DATA;
    end else if (in_fire) begin
      plan_valid <= has_result;
      plan_slot  <= start_slot;
      plan_last  <= end_slot;
    end else if (load) begin
      if (plan_slot == plan_last) begin
        plan_valid <= 1'b0;
      end else begin
        plan_slot <= plan_slot + slot_t'(1);
      end
    end
  end

  // Hold plan payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      plan_total  <= total;
      plan_offset <= page_offset;
      plan_used   <= used;
      plan_data   <= data_byte;
      plan_sum    <= sum_after;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= slot_byte;
      frame_end  <= (plan_slot == SLOT_SUM_HI) || (plan_slot == SLOT_REJECT);
      rejected   <= (plan_slot == SLOT_REJECT);
    end
  end

endmodule
